FILE: src/event_throttle_coalescer_assert.svh
// assertion macros used by the controller
`ifndef EVENT_THROTTLE_COALESCER_ASSERT_SVH
`define EVENT_THROTTLE_COALESCER_ASSERT_SVH

// same-cycle implication
`define ETC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/etc_pkg.sv
package etc_pkg;

    localparam int ETC_DEPTH       = 16;
    localparam int ETC_DATA_W      = 32;
    localparam int ETC_RUNLEN_W    = 5;
    localparam int ETC_TICK_W      = 16;
    localparam int ETC_LIMIT_W     = 5;
    localparam int ETC_CFG_IDX_W   = 2;
    localparam int ETC_CFG_DATA_W  = 16;
    localparam int ETC_OUT_TDATA_W = 40;

    localparam logic [ETC_TICK_W-1:0] ETC_INTERVAL_RST = 16'd1000;

    localparam logic [ETC_CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [ETC_CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [ETC_CFG_IDX_W-1:0] CFG_APPEND   = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } etc_state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic advance;
    } etc_cmd_t;

    typedef struct packed {
        logic flush;
        logic last;
    } etc_sts_t;

endpackage

FILE: src/etc_dpath.sv
module etc_dpath
    import etc_pkg::*;
#(
    parameter int BUFFER_DEPTH = ETC_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  etc_cmd_t                  cmd,
    output etc_sts_t                  sts,
    input  logic                      in_kind,
    input  logic [ETC_DATA_W-1:0]     in_data,
    input  logic                      cfg_we,
    input  logic [ETC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [ETC_CFG_DATA_W-1:0] cfg_data,
    output logic [ETC_DATA_W-1:0]     item_value,
    output logic [ETC_RUNLEN_W-1:0]   run_length
);

    localparam int CW   = $clog2(BUFFER_DEPTH + 1);
    localparam int AW   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CMPW = (CW > ETC_LIMIT_W) ? CW : ETC_LIMIT_W;

    logic [ETC_DATA_W-1:0]  mem [BUFFER_DEPTH];

    logic [ETC_TICK_W-1:0]  interval_reg;
    logic [ETC_LIMIT_W-1:0] limit_reg;
    logic                   append_reg;

    logic [CW-1:0]          count_reg, count_next;
    logic [ETC_TICK_W-1:0]  ticks_reg, ticks_next;
    logic                   armed_reg, armed_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic [CW-1:0]          run_len_reg, run_len_next;
    logic [ETC_DATA_W-1:0]  rd_data_reg;

    logic [ETC_TICK_W-1:0]  ticks_dec;
    logic [CW-1:0]          count_after;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   flush;
    logic [CW+ETC_RUNLEN_W-1:0] rl_wide;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= ETC_INTERVAL_RST;
            limit_reg    <= '0;
            append_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data[ETC_LIMIT_W-1:0];
                CFG_APPEND:   append_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        ticks_dec    = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;
        count_after  = count_reg;
        count_next   = count_reg;
        ticks_next   = ticks_reg;
        armed_next   = armed_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        flush        = 1'b0;
        run_len_next = run_len_reg;
        rd_idx_next  = rd_idx_reg;

        if (cmd.accept)
        begin
            if (in_kind == KIND_TICK)
            begin
                ticks_next = ticks_dec;
                if (armed_reg && ticks_dec == '0 && count_reg != '0)
                    flush = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                if (!append_reg)
                begin
                    wr_addr     = '0;
                    count_after = CW'(1);
                end
                else if (count_reg < CW'(BUFFER_DEPTH))
                begin
                    wr_addr     = count_reg[AW-1:0];
                    count_after = count_reg + 1'b1;
                end
                else
                begin
                    // full buffer: newest word overwrites the tail
                    wr_addr     = AW'(BUFFER_DEPTH - 1);
                    count_after = count_reg;
                end
                count_next = count_after;
                if (ticks_reg == '0)
                    flush = 1'b1;
                else
                begin
                    armed_next = 1'b1;
                    if (append_reg &&
                        ((limit_reg != '0 && CMPW'(count_after) >= CMPW'(limit_reg)) ||
                         count_after >= CW'(BUFFER_DEPTH)))
                        flush = 1'b1;
                end
            end

            if (flush)
            begin
                run_len_next = (in_kind == KIND_TICK) ? count_reg : count_after;
                rd_idx_next  = '0;
                count_next   = '0;
                armed_next   = 1'b0;
                ticks_next   = interval_reg;
            end
        end
        else if (cmd.advance)
            rd_idx_next = rd_idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ticks_reg   <= '0;
            armed_reg   <= 1'b0;
            rd_idx_reg  <= '0;
            run_len_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            ticks_reg   <= ticks_next;
            armed_reg   <= armed_next;
            rd_idx_reg  <= rd_idx_next;
            run_len_reg <= run_len_next;
        end
    end

    // pending store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
            rd_data_reg <= mem[rd_idx_reg];
    end

    assign rl_wide    = {{ETC_RUNLEN_W{1'b0}}, run_len_reg};
    assign item_value = rd_data_reg;
    assign run_length = rl_wide[ETC_RUNLEN_W-1:0];

    assign sts.flush = flush;
    assign sts.last  = (CW'(rd_idx_reg) + 1'b1) == run_len_reg;

endmodule

FILE: src/etc_ctrl.sv
`include "event_throttle_coalescer_assert.svh"

module etc_ctrl
    import etc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output etc_cmd_t cmd,
    input  etc_sts_t sts
);

    etc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.fetch   = 1'b0;
        cmd.advance = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && sts.flush)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `ETC_ASSERT_IMP(a_no_in_while_out, out_valid, !in_ready, "input taken during drain")
    `ETC_ASSERT_NXT(a_flush_starts, cmd.accept && sts.flush, state_reg == ST_FETCH, "flush did not start drain")
    `ETC_ASSERT_NXT(a_last_ends, out_valid && out_ready && sts.last, state_reg == ST_IDLE, "drain did not end on last beat")
    `ETC_ASSERT_NXT(a_fetch_shows, cmd.fetch, out_valid, "fetched word not shown")

endmodule

FILE: src/event_throttle_coalescer.sv
// Event throttle coalescer. Events (s_tuser = 0) and time ticks (s_tuser = 1) arrive on the
// slave stream; each event is held in a pending buffer (latest only, or appended in batch
// mode) and flushed on the master stream as a run of words ending in tlast, at once when no
// interval is running, otherwise on the tick that ends the interval, or early in batch mode
// when the batch limit or a full buffer is reached. Input is held off while a flush drains,
// including any master stall: the pending buffer has a single registered read port, so each
// word is fetched in ST_FETCH, then shown in ST_SHOW. Configuration registers: 0 interval in
// ticks, 1 batch limit, 2 append mode.
module event_throttle_coalescer
    import etc_pkg::*;
#(
    parameter int BUFFER_DEPTH = ETC_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ETC_DATA_W-1:0]      s_tdata,   // event_value
    input  logic                       s_tuser,   // command
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ETC_OUT_TDATA_W-1:0] m_tdata,   // item_value, run_length, zero pad
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ETC_CFG_IDX_W-1:0]   cfg_index,
    input  logic [ETC_CFG_DATA_W-1:0]  cfg_data
);

    etc_cmd_t                cmd;
    etc_sts_t                sts;
    logic [ETC_DATA_W-1:0]   item_value;
    logic [ETC_RUNLEN_W-1:0] run_length;

    assign cfg_ready = 1'b1;

    etc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    etc_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_kind    (s_tuser),
        .in_data    (s_tdata),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_value (item_value),
        .run_length (run_length)
    );

    assign m_tdata = {{(ETC_OUT_TDATA_W - ETC_DATA_W - ETC_RUNLEN_W){1'b0}},
                      run_length, item_value};
    assign m_tlast = sts.last;

endmodule

FILE: dv/tb.sv
module tb;
    import etc_pkg::*;

    typedef enum logic {
        ROW_REG,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        logic [ETC_DATA_W-1:0]   word;
        logic [ETC_RUNLEN_W-1:0] run_len;
        logic                    last;
    } flush_word_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [ETC_CFG_IDX_W-1:0] reg_idx;
        logic                     cmd;
        logic [ETC_DATA_W-1:0]    value;
        logic [4:0]               copies;
        logic                     typed;
        flush_word_t              typed_word;
    } stim_row_t;

    localparam int N_ROWS = 21;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BEATS = 380;

    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'hFFFF_FFFF, 5'd1, 1'b1,
          '{32'hFFFF_FFFF, 5'd1, 1'b1}},
        '{ROW_BEAT, CFG_INTERVAL, KIND_TICK,  32'hFFFF_FFFF, 5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h0000_0000, 5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h1234_5678, 5'd1, 1'b0, '0},
        '{ROW_REG,  CFG_APPEND,   KIND_EVENT, 32'd1,         5'd1, 1'b0, '0},
        '{ROW_REG,  CFG_LIMIT,    KIND_EVENT, 32'd3,         5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'hA5A5_A5A5, 5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h5A5A_5A5A, 5'd1, 1'b0, '0},
        '{ROW_REG,  CFG_INTERVAL, KIND_EVENT, 32'd0,         5'd1, 1'b0, '0},
        '{ROW_REG,  CFG_LIMIT,    KIND_EVENT, 32'd1,         5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h0000_0001, 5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h8000_0000, 5'd1, 1'b1,
          '{32'h8000_0000, 5'd1, 1'b1}},
        '{ROW_REG,  CFG_INTERVAL, KIND_EVENT, 32'd2,         5'd1, 1'b0, '0},
        '{ROW_REG,  CFG_LIMIT,    KIND_EVENT, 32'd31,        5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'h0000_FFFF, 5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'hFFFF_0000, 5'd2, 1'b0, '0},
        '{ROW_REG,  CFG_INTERVAL, KIND_EVENT, 32'd65535,     5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_TICK,  32'h0000_0000, 5'd2, 1'b0, '0},
        '{ROW_REG,  CFG_LIMIT,    KIND_EVENT, 32'd0,         5'd1, 1'b0, '0},
        '{ROW_BEAT, CFG_INTERVAL, KIND_EVENT, 32'hC000_0000, 5'd16, 1'b0, '0},
        '{ROW_REG,  CFG_APPEND,   KIND_EVENT, 32'd0,         5'd1, 1'b0, '0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [ETC_DATA_W-1:0]      s_tdata = '0;      // event_value
    logic                       s_tuser = KIND_EVENT;  // command
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [ETC_OUT_TDATA_W-1:0] m_tdata;           // item_value, run_length, zero pad
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [ETC_CFG_IDX_W-1:0]   cfg_index = CFG_INTERVAL;
    logic [ETC_CFG_DATA_W-1:0]  cfg_data = '0;

    logic [ETC_TICK_W-1:0]  interval_mirror = ETC_INTERVAL_RST;
    logic [ETC_LIMIT_W-1:0] limit_mirror = '0;
    logic                   append_mirror = 1'b0;
    logic [ETC_DATA_W-1:0]  held_words [ETC_DEPTH];
    int unsigned            held_count = 0;
    logic [ETC_TICK_W-1:0]  ticks_left = '0;
    logic                   flush_armed = 1'b0;
    flush_word_t            expected_words [$];
    flush_word_t            want;

    logic quiet = 1'b0;
    logic long_hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   errors = 0;
    int   beats_in = 0;
    int   words_checked = 0;
    int   longest_run = 0;
    int   settings = 0;

    always #5 clk = ~clk;

    event_throttle_coalescer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int flush_held();
        int n;
        n = held_count;
        if (n == 0)
            return 0;
        for (int i = 0; i < n; i++)
            expected_words.push_back('{held_words[i], ETC_RUNLEN_W'(n), i == n - 1});
        held_count = 0;
        flush_armed = 1'b0;
        ticks_left = interval_mirror;
        return n;
    endfunction

    // returns the number of words the beat is predicted to release
    function automatic int coalesce_beat(input logic cmd, input logic [ETC_DATA_W-1:0] val);
        int n;
        n = 0;
        if (cmd == KIND_TICK)
        begin
            if (ticks_left != 0)
                ticks_left = ticks_left - 1'b1;
            if (flush_armed && ticks_left == 0)
                n = flush_held();
            return n;
        end
        if (!append_mirror)
        begin
            held_words[0] = val;
            held_count = 1;
        end
        else if (held_count < ETC_DEPTH)
        begin
            held_words[held_count] = val;
            held_count++;
        end
        else
            held_words[ETC_DEPTH-1] = val;
        if (ticks_left == 0)
            n = flush_held();
        else
            flush_armed = 1'b1;
        if (n == 0 && append_mirror &&
            ((limit_mirror != 0 && held_count >= limit_mirror) || held_count >= ETC_DEPTH))
            n = flush_held();
        return n;
    endfunction

    task automatic write_reg(input logic [ETC_CFG_IDX_W-1:0] idx,
                             input logic [ETC_CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INTERVAL: interval_mirror = val;
            CFG_LIMIT:    limit_mirror = val[ETC_LIMIT_W-1:0];
            CFG_APPEND:   append_mirror = val[0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_beat(input logic cmd, input logic [ETC_DATA_W-1:0] val,
                             output int pushed);
        if (!quiet && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        beats_in++;
        pushed = coalesce_beat(cmd, val);
    endtask

    // wait for the flush queue to empty, then give the block time to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got word %h len %0d last %b",
                         $time, m_tdata[ETC_DATA_W-1:0],
                         m_tdata[ETC_DATA_W +: ETC_RUNLEN_W], m_tlast);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata[ETC_DATA_W-1:0] !== want.word ||
                    m_tdata[ETC_DATA_W +: ETC_RUNLEN_W] !== want.run_len ||
                    m_tlast !== want.last)
                begin
                    $display({"%0t: mismatch, expected word %h len %0d last %b, ",
                              "got word %h len %0d last %b"},
                             $time, want.word, want.run_len, want.last,
                             m_tdata[ETC_DATA_W-1:0], m_tdata[ETC_DATA_W +: ETC_RUNLEN_W],
                             m_tlast);
                    errors++;
                end
                words_checked++;
                if (int'(want.run_len) > longest_run)
                    longest_run = int'(want.run_len);
            end
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || $urandom_range(99) >= 7;
    end

    initial
    begin
        int pushed;
        int total_rand;
        int phase;
        int phase_items;
        stim_row_t row;
        logic cmd;
        logic [ETC_DATA_W-1:0] val;
        logic [ETC_TICK_W-1:0] new_interval;
        logic [ETC_LIMIT_W-1:0] new_limit;

        total_rand = 0;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_REG)
            begin
                settle();
                write_reg(row.reg_idx, row.value[ETC_CFG_DATA_W-1:0]);
            end
            else
            begin
                for (int c = 0; c < row.copies; c++)
                begin
                    send_beat(row.cmd, row.value + ETC_DATA_W'(c), pushed);
                    if (row.typed)
                    begin
                        repeat (pushed) void'(expected_words.pop_back());
                        expected_words.push_back(row.typed_word);
                    end
                end
            end
        end

        while (total_rand < RANDOM_BEATS)
        begin
            settle();
            quiet <= (phase == 5 || phase == 6);
            case ($urandom_range(9))
                0:       new_interval = '0;
                1:       new_interval = '1;
                default: new_interval = ETC_TICK_W'($urandom_range(1, 6));
            endcase
            if (phase == 2)
                new_interval = '0;
            write_reg(CFG_INTERVAL, new_interval);
            // a long interval left running would hold every later event back
            if (ticks_left > 64 && new_interval < 64)
            begin
                write_reg(CFG_APPEND, ETC_CFG_DATA_W'(1));
                write_reg(CFG_LIMIT, ETC_CFG_DATA_W'(1));
                send_beat(KIND_EVENT, $urandom(), pushed);
                settle();
            end
            case ($urandom_range(9))
                0:       new_limit = '0;
                1:       new_limit = '1;
                2:       new_limit = ETC_LIMIT_W'(ETC_DEPTH);
                default: new_limit = ETC_LIMIT_W'($urandom_range(1, 20));
            endcase
            write_reg(CFG_LIMIT, ETC_CFG_DATA_W'(new_limit));
            write_reg(CFG_APPEND, ETC_CFG_DATA_W'((phase == 2) ? 0 : $urandom_range(1)));
            settings++;
            if (phase == 2)
                long_hold_req <= 1'b1;
            phase_items = $urandom_range(30, 50);
            for (int k = 0; k < phase_items; k++)
            begin
                cmd = ($urandom_range(99) < ((new_interval == '1) ? 10 : 45)) ? KIND_TICK
                                                                                : KIND_EVENT;
                case ($urandom_range(9))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom();
                endcase
                send_beat(cmd, val, pushed);
            end
            total_rand += phase_items;
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        $display("%0d input beats (%0d random over %0d register settings), %0d words checked",
                 beats_in, total_rand, settings, words_checked);
        $display("longest flush %0d words, output held off %0d cycles once under load",
                 longest_run, HOLD_CYCLES);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/etc_pkg.sv
src/etc_dpath.sv
src/etc_ctrl.sv
src/event_throttle_coalescer.sv
dv/tb.sv
